### src/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg: shared types and constants of the shell command tokenizer
// Character codes, scan modes, result kinds, error codes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package sct_pkg;

    localparam logic [7:0] CH_NL  = 8'd10;
    localparam logic [7:0] CH_SP  = 8'd32;
    localparam logic [7:0] CH_DQ  = 8'd34;
    localparam logic [7:0] CH_SQ  = 8'd39;
    localparam logic [7:0] CH_LT  = 8'd60;
    localparam logic [7:0] CH_GT  = 8'd62;
    localparam logic [7:0] CH_BAR = 8'd124;
    localparam logic [7:0] PRINT_LO = 8'd32;
    localparam logic [7:0] PRINT_HI = 8'd127;

    typedef enum logic [2:0] {
        MODE_START = 3'd0,
        MODE_BLANK = 3'd1,
        MODE_WORD  = 3'd2,
        MODE_OPER  = 3'd3,
        MODE_SQ    = 3'd4,
        MODE_DQ    = 3'd5,
        MODE_DROP  = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        K_BYTE = 2'd0,
        K_END  = 2'd1,
        K_OK   = 2'd2,
        K_ERR  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_OP_FIRST  = 3'd1,
        ERR_BAD_BYTE  = 3'd2,
        ERR_OP_LAST   = 3'd3,
        ERR_OP_PAIR   = 3'd4,
        ERR_TRIPLE_GT = 3'd5,
        ERR_UNCLOSED  = 3'd6
    } err_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_byte;
        logic       is_operator;
        err_t       error_code;
        logic       last;
    } result_t;

    function automatic result_t mk_result(kind_t k, logic [7:0] b, logic op, err_t e);
        result_t r;
        r.kind        = k;
        r.out_byte    = b;
        r.is_operator = op;
        r.error_code  = e;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

### src/sct_if.sv
// ----------------------------------------------------------------------------
// sct_in_if / sct_out_if: valid/ready channels of the tokenizer
// One channel carries command line bytes, the other carries token results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sct_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface sct_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       is_operator;
    logic [2:0] error_code;
    logic       last;

    modport source (output valid, output kind, output out_byte, output is_operator,
                    output error_code, output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input is_operator,
                    input error_code, input last, output ready);
endinterface

`default_nettype wire

### src/sct_lexer.sv
// ----------------------------------------------------------------------------
// sct_lexer: scan state and per-byte decode
// Holds the scan mode, previous byte and operator length, and works out the
// zero, one or two results that a byte gives.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_lexer (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire logic [7:0]       in_byte,
    output logic [1:0]            n_results,
    output sct_pkg::result_t      res0,
    output sct_pkg::result_t      res1
);
    import sct_pkg::*;

    mode_t      mode_reg, mode_next;
    logic [7:0] prev_reg;
    logic [1:0] oplen_reg, oplen_next;

    logic is_op, printable, in_word;
    err_t err;
    logic [1:0] n;
    result_t r0, r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_START;
            prev_reg  <= 8'd0;
            oplen_reg <= 2'd0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            prev_reg  <= in_byte;
            oplen_reg <= oplen_next;
        end
    end

    always_comb
    begin
        is_op      = (in_byte == CH_LT) || (in_byte == CH_GT) || (in_byte == CH_BAR);
        printable  = (in_byte >= PRINT_LO) && (in_byte <= PRINT_HI);
        in_word    = (mode_reg == MODE_WORD);
        err        = ERR_NONE;
        n          = 2'd0;
        r0         = mk_result(K_BYTE, 8'd0, 1'b0, ERR_NONE);
        r1         = mk_result(K_BYTE, 8'd0, 1'b0, ERR_NONE);
        mode_next  = mode_reg;
        oplen_next = oplen_reg;

        if (in_byte == CH_NL)
        begin
            case (mode_reg)
                MODE_WORD:
                begin
                    r0 = mk_result(K_END, 8'd0, 1'b0, ERR_NONE);
                    r1 = mk_result(K_OK, 8'd0, 1'b0, ERR_NONE);
                    n  = 2'd2;
                end
                MODE_OPER:
                begin
                    r0 = mk_result(K_ERR, 8'd0, 1'b0, ERR_OP_LAST);
                    n  = 2'd1;
                end
                MODE_SQ, MODE_DQ:
                begin
                    r0 = mk_result(K_ERR, 8'd0, 1'b0, ERR_UNCLOSED);
                    n  = 2'd1;
                end
                MODE_DROP: ;
                default:
                begin
                    r0 = mk_result(K_OK, 8'd0, 1'b0, ERR_NONE);
                    n  = 2'd1;
                end
            endcase
            mode_next  = MODE_START;
            oplen_next = 2'd0;
        end
        else
        begin
            case (mode_reg)
                MODE_DROP: ;
                MODE_SQ, MODE_DQ:
                begin
                    if (in_byte == ((mode_reg == MODE_SQ) ? CH_SQ : CH_DQ))
                    begin
                        r0        = mk_result(K_END, 8'd0, 1'b0, ERR_NONE);
                        mode_next = MODE_BLANK;
                    end
                    else
                    begin
                        r0 = mk_result(K_BYTE, in_byte, 1'b0, ERR_NONE);
                    end
                    n = 2'd1;
                end
                MODE_OPER:
                begin
                    if ((in_byte == CH_DQ) || (in_byte == CH_SQ))
                    begin
                        r0         = mk_result(K_END, 8'd0, 1'b1, ERR_NONE);
                        n          = 2'd1;
                        mode_next  = (in_byte == CH_DQ) ? MODE_DQ : MODE_SQ;
                        oplen_next = 2'd0;
                    end
                    else if ((in_byte == CH_LT) || (in_byte == CH_BAR))
                    begin
                        err = ERR_OP_PAIR;
                    end
                    else if (in_byte == CH_GT)
                    begin
                        if (prev_reg != CH_GT)
                            err = ERR_OP_PAIR;
                        else if (oplen_reg >= 2'd2)
                            err = ERR_TRIPLE_GT;
                        else
                        begin
                            r0         = mk_result(K_BYTE, in_byte, 1'b1, ERR_NONE);
                            n          = 2'd1;
                            oplen_next = 2'd2;
                        end
                    end
                    else if (in_byte == CH_SP)
                    begin
                        // spaces after an operator are skipped
                    end
                    else if (printable)
                    begin
                        r0         = mk_result(K_END, 8'd0, 1'b1, ERR_NONE);
                        r1         = mk_result(K_BYTE, in_byte, 1'b0, ERR_NONE);
                        n          = 2'd2;
                        mode_next  = MODE_WORD;
                        oplen_next = 2'd0;
                    end
                    else
                    begin
                        err = ERR_BAD_BYTE;
                    end
                end
                default:
                begin
                    // line start, blank and word; the spare mode code acts as line start
                    if ((in_byte == CH_DQ) || (in_byte == CH_SQ))
                    begin
                        if (in_word)
                        begin
                            r0 = mk_result(K_END, 8'd0, 1'b0, ERR_NONE);
                            n  = 2'd1;
                        end
                        mode_next = (in_byte == CH_DQ) ? MODE_DQ : MODE_SQ;
                    end
                    else if (is_op)
                    begin
                        if ((mode_reg != MODE_BLANK) && !in_word)
                            err = ERR_OP_FIRST;
                        else
                        begin
                            if (in_word)
                            begin
                                r0 = mk_result(K_END, 8'd0, 1'b0, ERR_NONE);
                                r1 = mk_result(K_BYTE, in_byte, 1'b1, ERR_NONE);
                                n  = 2'd2;
                            end
                            else
                            begin
                                r0 = mk_result(K_BYTE, in_byte, 1'b1, ERR_NONE);
                                n  = 2'd1;
                            end
                            mode_next  = MODE_OPER;
                            oplen_next = 2'd1;
                        end
                    end
                    else if (in_byte == CH_SP)
                    begin
                        if (in_word)
                        begin
                            r0        = mk_result(K_END, 8'd0, 1'b0, ERR_NONE);
                            n         = 2'd1;
                            mode_next = MODE_BLANK;
                        end
                    end
                    else if (printable)
                    begin
                        r0        = mk_result(K_BYTE, in_byte, 1'b0, ERR_NONE);
                        n         = 2'd1;
                        mode_next = MODE_WORD;
                    end
                    else
                    begin
                        err = ERR_BAD_BYTE;
                    end
                end
            endcase

            // no error path has emitted anything before it
            if (err != ERR_NONE)
            begin
                r0         = mk_result(K_ERR, 8'd0, 1'b0, err);
                n          = 2'd1;
                mode_next  = MODE_DROP;
                oplen_next = 2'd0;
            end
        end

        if (n == 2'd1)
            r0.last = 1'b1;
        if (n == 2'd2)
            r1.last = 1'b1;

        n_results = n;
        res0      = r0;
        res1      = r1;
    end

`ifndef SYNTHESIS
    a_err_drops: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (n_results == 2'd1) && (res0.kind == K_ERR) && (in_byte != CH_NL)
        |=> mode_reg == MODE_DROP)
        else $error("error result not followed by drop mode");

    a_oplen_only_oper: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_OPER) |-> (oplen_reg == 2'd0))
        else $error("operator length set outside operator mode");

    a_pair_ends_token: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (n_results == 2'd2) |-> (res0.kind == K_END) && !res0.last && res1.last)
        else $error("two results without a leading end marker");
`endif

endmodule

`default_nettype wire

### src/shell_command_tokenizer.sv
// ----------------------------------------------------------------------------
// shell_command_tokenizer: streaming lexer for command lines
// Turns a byte stream into token bytes, end markers and per-line verdicts.
// ----------------------------------------------------------------------------
// A byte is taken on every cycle while results drain: bytes pass through an
// input register, are decoded against the scan state, and their zero, one or
// two results enter a two-entry result queue that feeds the output channel.
// A result is presented from the queue register, which follows the input
// register that takes its byte. The queue port moves one result per cycle
// while the output is ready, so a byte that gives two results (an end marker
// plus a byte or a verdict) holds the output until both are taken in turn, and
// the input stalls only while the queue lacks room for the next byte's results.
// ----------------------------------------------------------------------------
`default_nettype none

module shell_command_tokenizer (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sct_in_if.sink     char_stream,
    sct_out_if.source  token_stream
);
    import sct_pkg::*;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;

    logic [1:0] n_results;
    result_t    res0, res1;
    logic       fire, pop;

    result_t    q0_reg, q1_reg, q0_next, q1_next;
    logic [1:0] count_reg, count_next, c_after;
    result_t    e0, e1;

    assign pop  = (count_reg != 2'd0) && token_stream.ready;
    assign fire = s1_valid_reg &&
                  (({1'b0, n_results} + {1'b0, count_reg}) <= (3'd2 + {2'b00, pop}));

    assign char_stream.ready = !s1_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (char_stream.ready)
            s1_valid_reg <= char_stream.valid;
    end

    always_ff @(posedge clk)
    begin
        if (char_stream.ready && char_stream.valid)
            s1_byte_reg <= char_stream.in_byte;
    end

    sct_lexer u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .in_byte   (s1_byte_reg),
        .n_results (n_results),
        .res0      (res0),
        .res1      (res1)
    );

    // shift out the head, then append the new results behind what is left
    always_comb
    begin
        c_after = count_reg - {1'b0, pop};
        e0      = pop ? q1_reg : q0_reg;
        e1      = q1_reg;
        q0_next = e0;
        q1_next = e1;
        if (fire)
        begin
            if (c_after == 2'd0)
            begin
                q0_next = res0;
                q1_next = res1;
            end
            else if (c_after == 2'd1)
                q1_next = res0;
        end
        count_next = c_after + (fire ? n_results : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign token_stream.valid       = (count_reg != 2'd0);
    assign token_stream.kind        = q0_reg.kind;
    assign token_stream.out_byte    = q0_reg.out_byte;
    assign token_stream.is_operator = q0_reg.is_operator;
    assign token_stream.error_code  = q0_reg.error_code;
    assign token_stream.last        = q0_reg.last;

endmodule

`default_nettype wire
